FILE: src/ale_pkg.sv
// Package for the array list engine: command and status codes, control state type.
// No dependencies.
package ale_pkg;

  localparam logic [2:0] CMD_INS_POS  = 3'd0;
  localparam logic [2:0] CMD_INS_HEAD = 3'd1;
  localparam logic [2:0] CMD_APPEND   = 3'd2;
  localparam logic [2:0] CMD_DEL_POS  = 3'd3;
  localparam logic [2:0] CMD_DEL_VAL  = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;
  localparam logic [2:0] CMD_SEARCH   = 3'd6;
  localparam logic [2:0] CMD_REVERSE  = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_SORT_TOP,
    S_SORT_KEY,
    S_SORT_J,
    S_SORT_CMP,
    S_BS_TOP,
    S_BS_CMP,
    S_REV_TOP,
    S_DONE
  } ale_state_e;

  typedef enum logic [1:0] {
    R_RB,
    R_WA,
    R_WB
  } ale_rev_e;

endpackage

FILE: src/ale_ram.sv
// Entry store of the array list engine: one write port, one registered read port.
// No dependencies.
module ale_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: src/array_list_engine.sv
// Array list engine top level: command sequencer around the entry store.
// Depends on ale_pkg and ale_ram.
//
//  channel | signals                                          | dir
//  in      | in_valid_i, in_stall_o, cmd_i, item_value_i,     | in
//          | position_i                                       |
//  out     | out_valid_o, out_stall_i, status_o, read_value_o,| out
//          | found_index_o, list_length_o                     |
//
// One command at a time; each store read is registered before its data is used.
// Insert/delete: a read and a write state per entry moved. Read: issue, then wait.
// Reverse: two reads, two writes per pair. Search/delete by value: insertion sort,
// then binary search with a top and a compare state per step; one store port pair.
// Reset clears the length; the store needs no clearing.
// A new command is taken while the previous result waits under stall.
module array_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     cmd_i,
  input  logic signed [31:0]             item_value_i,
  input  logic [$clog2(CAPACITY+1)-1:0]  position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic signed [31:0]             read_value_o,
  output logic [$clog2(CAPACITY)-1:0]    found_index_o,
  output logic [$clog2(CAPACITY+1)-1:0]  list_length_o
);
  import ale_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  ale_state_e state_q, state_d;
  ale_rev_e   rph_q, rph_d;
  logic       rev_wb2_q, rev_wb2_d;

  logic [2:0]    cmd_q, cmd_d;
  logic [31:0]   val_q, val_d;
  logic [31:0]   tmp_q, tmp_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hp_q, hp_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   rval_q, rval_d;
  logic [IW-1:0] fidx_q, fidx_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q;
  logic [31:0]   out_rval_q;
  logic [IW-1:0] out_fidx_q;
  logic [CW-1:0] out_len_q;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic          accept, full, ins_bad, pos_bad, out_free, gt, eq;
  logic [CW-1:0] ins_idx, mid;

  ale_ram #(.DEPTH(CAPACITY), .AW(IW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CAP);
  assign ins_bad    = (position_i == '0) ||
                      ({1'b0, position_i} > ({1'b0, count_q} + {1'b0, ONE}));
  assign pos_bad    = (position_i == '0) || (position_i > count_q);
  assign ins_idx    = (cmd_i == CMD_INS_HEAD) ? '0 :
                      (cmd_i == CMD_APPEND) ? count_q : position_i - ONE;
  assign mid        = lo_q + ((hp_q - ONE - lo_q) >> 1);
  assign gt         = $signed(rdata) > $signed(tmp_q);
  assign eq         = (rdata == val_q);

  // next state
  always_comb begin
    state_d = state_q;
    rph_d   = rph_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_INS_POS, CMD_INS_HEAD, CMD_APPEND: begin
              if (full || (cmd_i == CMD_INS_POS && ins_bad)) begin
                state_d = S_DONE;
              end else if (count_q > ins_idx) begin
                state_d = S_INS_RD;
              end else begin
                state_d = S_PUT;
              end
            end
            CMD_DEL_POS: state_d = pos_bad ? S_DONE : S_DEL_RD;
            CMD_READ:    state_d = pos_bad ? S_DONE : S_RD_ISSUE;
            CMD_DEL_VAL, CMD_SEARCH: state_d = S_SORT_TOP;
            default: begin
              state_d = S_REV_TOP;
            end
          endcase
        end
      end
      S_INS_RD: state_d = S_INS_WR;
      S_INS_WR: state_d = ((i_q - ONE) > j_q) ? S_INS_RD : S_PUT;
      S_PUT:    state_d = S_DONE;
      S_DEL_RD: state_d = ((i_q + ONE) < count_q) ? S_DEL_WR : S_DONE;
      S_DEL_WR: state_d = S_DEL_RD;
      S_RD_ISSUE: state_d = S_RD_WAIT;
      S_RD_WAIT:  state_d = S_DONE;
      S_SORT_TOP: state_d = (i_q < count_q) ? S_SORT_KEY : S_BS_TOP;
      S_SORT_KEY: state_d = S_SORT_J;
      S_SORT_J:   state_d = (j_q != '0) ? S_SORT_CMP : S_SORT_TOP;
      S_SORT_CMP: state_d = gt ? S_SORT_J : S_SORT_TOP;
      S_BS_TOP:   state_d = (lo_q < hp_q) ? S_BS_CMP : S_DONE;
      S_BS_CMP: begin
        if (eq) begin
          state_d = (cmd_q == CMD_DEL_VAL) ? S_DEL_RD : S_DONE;
        end else begin
          state_d = S_BS_TOP;
        end
      end
      S_REV_TOP: begin
        if (rph_q == R_RB) begin
          state_d = ((i_q + ONE) < j_q) ? S_REV_TOP : S_DONE;
          rph_d   = ((i_q + ONE) < j_q) ? R_WA : R_RB;
        end else if (rph_q == R_WA) begin
          rph_d = R_WB;
        end else begin
          rph_d = rev_wb2_q ? R_RB : R_WB;
        end
      end
      S_DONE: state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // Reverse runs in S_REV_TOP with phases: R_RB checks and reads a,
  // R_WA captures a and reads b-1, R_WB writes a then b-1, toggling rev_wb2.

  // datapath and result
  always_comb begin
    cmd_d     = cmd_q;
    val_d     = val_q;
    tmp_d     = tmp_q;
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    lo_d      = lo_q;
    hp_d      = hp_q;
    status_d  = status_q;
    rval_d    = rval_q;
    fidx_d    = fidx_q;
    rev_wb2_d = rev_wb2_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_i;
          val_d     = item_value_i;
          status_d  = ST_OK;
          rval_d    = '0;
          fidx_d    = '0;
          rev_wb2_d = 1'b0;
          case (cmd_i)
            CMD_INS_POS, CMD_INS_HEAD, CMD_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (cmd_i == CMD_INS_POS && ins_bad) begin
                status_d = ST_BAD_POS;
              end
              i_d = count_q;
              j_d = ins_idx;
            end
            CMD_DEL_POS, CMD_READ: begin
              if (pos_bad) begin
                status_d = ST_BAD_POS;
              end
              i_d = position_i - ONE;
            end
            CMD_DEL_VAL, CMD_SEARCH: begin
              i_d = ONE;
            end
            default: begin
              i_d = '0;
              j_d = count_q;
            end
          endcase
        end
      end
      S_INS_WR: i_d = i_q - ONE;
      S_PUT:    count_d = count_q + ONE;
      S_DEL_RD: begin
        if (!((i_q + ONE) < count_q)) begin
          count_d = count_q - ONE;
        end
      end
      S_DEL_WR:  i_d = i_q + ONE;
      S_RD_WAIT: rval_d = rdata;
      S_SORT_TOP: begin
        j_d = i_q;
        if (!(i_q < count_q)) begin
          lo_d = '0;
          hp_d = count_q;
        end
      end
      S_SORT_KEY: tmp_d = rdata;
      S_SORT_J: begin
        if (j_q == '0) begin
          i_d = i_q + ONE;
        end
      end
      S_SORT_CMP: begin
        if (gt) begin
          j_d = j_q - ONE;
        end else begin
          i_d = i_q + ONE;
        end
      end
      S_BS_TOP: begin
        j_d = mid;
        if (!(lo_q < hp_q)) begin
          status_d = ST_NOT_FOUND;
        end
      end
      S_BS_CMP: begin
        if (eq) begin
          rval_d = val_q;
          fidx_d = j_q[IW-1:0];
          i_d    = j_q;
        end else if ($signed(rdata) > $signed(val_q)) begin
          hp_d = j_q;
        end else begin
          lo_d = j_q + ONE;
        end
      end
      S_REV_TOP: begin
        if (rph_q == R_WA) begin
          tmp_d = rdata;
        end else if (rph_q == R_WB) begin
          rev_wb2_d = !rev_wb2_q;
          if (rev_wb2_q) begin
            i_d = i_q + ONE;
            j_d = j_q - ONE;
          end
        end
      end
      default: ;
    endcase
  end

  // store port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state_q)
      S_INS_RD: raddr = IW'(i_q - ONE);
      S_INS_WR: begin
        we    = 1'b1;
        waddr = i_q[IW-1:0];
        wdata = rdata;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = j_q[IW-1:0];
        wdata = val_q;
      end
      S_DEL_RD: raddr = IW'(i_q + ONE);
      S_DEL_WR: begin
        we    = 1'b1;
        waddr = i_q[IW-1:0];
        wdata = rdata;
      end
      S_RD_ISSUE: raddr = i_q[IW-1:0];
      S_SORT_TOP: raddr = i_q[IW-1:0];
      S_SORT_J: begin
        if (j_q != '0) begin
          raddr = IW'(j_q - ONE);
        end else begin
          we    = 1'b1;
          waddr = j_q[IW-1:0];
          wdata = tmp_q;
        end
      end
      S_SORT_CMP: begin
        we    = 1'b1;
        waddr = j_q[IW-1:0];
        wdata = gt ? rdata : tmp_q;
      end
      S_BS_TOP: raddr = mid[IW-1:0];
      S_REV_TOP: begin
        case (rph_q)
          R_RB: raddr = i_q[IW-1:0];
          R_WA: raddr = IW'(j_q - ONE);
          default: begin
            we = 1'b1;
            if (!rev_wb2_q) begin
              waddr = i_q[IW-1:0];
              wdata = rdata;
            end else begin
              waddr = IW'(j_q - ONE);
              wdata = tmp_q;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid_d = (state_q == S_DONE && out_free) ? 1'b1 :
                       (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rph_q       <= R_RB;
      rev_wb2_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rph_q       <= rph_d;
      rev_wb2_q   <= rev_wb2_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    tmp_q    <= tmp_d;
    i_q      <= i_d;
    j_q      <= j_d;
    lo_q     <= lo_d;
    hp_q     <= hp_d;
    status_q <= status_d;
    rval_q   <= rval_d;
    fidx_q   <= fidx_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= status_q;
      out_rval_q   <= rval_q;
      out_fidx_q   <= fidx_q;
      out_len_q    <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_rval_q;
  assign found_index_o = out_fidx_q;
  assign list_length_o = out_len_q;
endmodule

FILE: verif/array_list_checker.sv
// Checker for the array list engine: watches both channels, predicts each result
// from its own list model and compares field by field. Depends on ale_pkg.
`timescale 1ns / 100ps
module array_list_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] item_value_i,
  input  logic [6:0]         position_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic signed [31:0] read_value_i,
  input  logic [5:0]         found_index_i,
  input  logic [6:0]         list_length_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import ale_pkg::*;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] rval;
    logic [5:0]         fidx;
    logic [6:0]         len;
  } list_result_t;

  logic signed [31:0] list_q[DEPTH];
  int                 list_len;
  list_result_t       result_q[$];

  assign pending_o = result_q.size();

  initial fail_count_o = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
    fail_count_o++;
  endtask

  task automatic sort_list();
    int                 j;
    logic signed [31:0] key;
    for (int i = 1; i < list_len; i++) begin
      key = list_q[i];
      j = i;
      while (j > 0 && list_q[j-1] > key) begin
        list_q[j] = list_q[j-1];
        j--;
      end
      list_q[j] = key;
    end
  endtask

  function automatic int find_value(logic signed [31:0] v);
    int lo, hi, mid;
    lo = 0;
    hi = list_len - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (list_q[mid] == v) return mid;
      if (list_q[mid] > v) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  task automatic insert_at(int idx, logic signed [31:0] v);
    for (int i = list_len; i > idx; i--) list_q[i] = list_q[i-1];
    list_q[idx] = v;
    list_len++;
  endtask

  task automatic remove_at(int idx);
    for (int i = idx; i + 1 < list_len; i++) list_q[i] = list_q[i+1];
    list_len--;
  endtask

  task automatic predict_command(logic [2:0] cmd, logic signed [31:0] v, int pos);
    list_result_t       r;
    int                 at, a, b;
    logic signed [31:0] t;
    r = '0;
    case (cmd)
      CMD_INS_POS, CMD_INS_HEAD, CMD_APPEND: begin
        if (list_len >= DEPTH) r.status = ST_FULL;
        else if (cmd == CMD_INS_HEAD) insert_at(0, v);
        else if (cmd == CMD_APPEND) insert_at(list_len, v);
        else if (pos < 1 || pos > list_len + 1) r.status = ST_BAD_POS;
        else insert_at(pos - 1, v);
      end
      CMD_DEL_POS: begin
        if (pos < 1 || pos > list_len) r.status = ST_BAD_POS;
        else remove_at(pos - 1);
      end
      CMD_DEL_VAL, CMD_SEARCH: begin
        sort_list();
        at = find_value(v);
        if (at < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.rval = v;
          r.fidx = at[5:0];
          if (cmd == CMD_DEL_VAL) remove_at(at);
        end
      end
      CMD_READ: begin
        if (pos < 1 || pos > list_len) r.status = ST_BAD_POS;
        else r.rval = list_q[pos-1];
      end
      default: begin
        a = 0;
        b = list_len;
        while (a + 1 < b) begin
          t = list_q[a];
          list_q[a] = list_q[b-1];
          list_q[b-1] = t;
          a++;
          b--;
        end
      end
    endcase
    r.len = list_len[6:0];
    result_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t e;
    if (!rst_ni) begin
      list_len = 0;
      result_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          e = result_q.pop_front();
          if (status_i !== e.status) report_mismatch("status", status_i, e.status);
          if (read_value_i !== e.rval) report_mismatch("read_value", read_value_i, e.rval);
          if (found_index_i !== e.fidx)
            report_mismatch("found_index", found_index_i, e.fidx);
          if (list_length_i !== e.len)
            report_mismatch("list_length", list_length_i, e.len);
        end
      end
      if (in_valid_i && !in_stall_i) predict_command(cmd_i, item_value_i, position_i);
    end
  end

endmodule

FILE: verif/tb_array_list_engine.sv
// Testbench top for the array list engine: drives directed and random commands
// with bursty valid and random stall. Depends on ale_pkg, array_list_engine and array_list_checker.
`timescale 1ns / 100ps
module tb_array_list_engine;
  import ale_pkg::*;

  localparam int  N_RANDOM = 1860;
  localparam longint LIMIT = 50000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         cmd_i = CMD_REVERSE;
  logic signed [31:0] item_value_i = '0;
  logic [6:0]         position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] read_value_o;
  logic [5:0]         found_index_o;
  logic [6:0]         list_length_o;
  int                 fail_count;
  int                 pending;
  longint             cycle_count = 0;
  int                 cur_len = 0;
  logic signed [31:0] val_pool[8];

  always #2 clk_i = ~clk_i;

  array_list_engine #(.CAPACITY(64)) u_top (.*);

  array_list_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .item_value_i,
    .position_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .read_value_i(read_value_o), .found_index_i(found_index_o),
    .list_length_i(list_length_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("array_list_engine test failed");
      $finish;
    end
  end

  // receiver stall pattern: phases of none, light and heavy stall
  always @(negedge clk_i) begin
    case ((cycle_count / 1500) % 3)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_beat(logic [2:0] c, logic signed [31:0] v, int p);
    cmd_i <= c;
    item_value_i <= v;
    position_i <= p[6:0];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    // track length roughly to steer positions
    case (c)
      CMD_INS_POS: if (cur_len < 64 && p >= 1 && p <= cur_len + 1) cur_len++;
      CMD_INS_HEAD, CMD_APPEND: if (cur_len < 64) cur_len++;
      CMD_DEL_POS: if (p >= 1 && p <= cur_len) cur_len--;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return val_pool[$urandom_range(0, 7)];
      1: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int burst;
    int p;
    logic [2:0] c;
    for (int i = 0; i < 8; i++) val_pool[i] = $urandom;
    val_pool[0] = 32'sh7fffffff;
    val_pool[1] = 32'sh80000000;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty-list cases, extremes, bad positions, full list
    send_beat(CMD_SEARCH, 0, 0);
    send_beat(CMD_DEL_VAL, 5, 0);
    send_beat(CMD_REVERSE, 0, 0);
    send_beat(CMD_READ, 0, 1);
    send_beat(CMD_DEL_POS, 0, 1);
    send_beat(CMD_INS_POS, 1, 2);
    send_beat(CMD_INS_POS, 32'sh7fffffff, 1);
    send_beat(CMD_INS_HEAD, 32'sh80000000, 127);
    send_beat(CMD_APPEND, -1, 0);
    send_beat(CMD_APPEND, -1, 0);
    send_beat(CMD_INS_POS, 7, 5);
    send_beat(CMD_READ, 0, 1);
    send_beat(CMD_READ, 0, 5);
    send_beat(CMD_READ, 0, 6);
    send_beat(CMD_REVERSE, 0, 0);
    send_beat(CMD_SEARCH, -1, 0);
    send_beat(CMD_SEARCH, 32'sh80000000, 0);
    send_beat(CMD_SEARCH, 3, 0);
    send_beat(CMD_DEL_VAL, 32'sh7fffffff, 0);
    send_beat(CMD_DEL_POS, 0, 0);
    send_beat(CMD_DEL_POS, 0, 4);
    while (cur_len < 64) send_beat(CMD_APPEND, $urandom_range(0, 20), 0);
    send_beat(CMD_INS_POS, 1, 1);
    send_beat(CMD_INS_HEAD, 1, 0);
    send_beat(CMD_APPEND, 1, 0);
    send_beat(CMD_SEARCH, 20, 0);
    send_beat(CMD_READ, 0, 64);
    send_beat(CMD_REVERSE, 0, 0);
    send_beat(CMD_DEL_POS, 0, 64);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        c = 3'($urandom_range(0, 7));
        // bias toward growth when short, shrink when long
        if (cur_len < 8 && $urandom_range(0, 1)) c = CMD_APPEND;
        if (cur_len > 40 && $urandom_range(0, 2) == 0) c = CMD_DEL_POS;
        if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 127);
        else p = $urandom_range(1, cur_len + 1);
        send_beat(c, rand_value(), p);
      end
      if ($urandom_range(0, 3) != 0) idle_gap();
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("array_list_engine test passed");
    else $display("array_list_engine test failed");
    $finish;
  end

endmodule
